// File: rtl/cube_sphere_vertex_gen_top_assert.svh
// Assertion macros used by the vertex generator top level.
`ifndef CUBE_SPHERE_VERTEX_GEN_TOP_ASSERT_SVH
`define CUBE_SPHERE_VERTEX_GEN_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CSV_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/csv_pkg.sv
// Types, widths and face table of the cube sphere vertex generator.
`default_nettype none

package csv_pkg;

  localparam int COORD_W    = 9;
  localparam int GS_W       = 10;
  localparam int FACE_W     = 3;
  localparam int IDX_W      = 18;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int U_W        = GS_W + 1;
  localparam int SQ_W       = 20;
  localparam int DD2_W      = 2 * SQ_W;
  localparam int DD3_W      = SQ_W + 2;
  localparam int SUV_W      = SQ_W + 1;
  localparam int DEN_W      = DD2_W + 3;
  localparam int RATIO_BITS = 28;
  localparam int Q_W        = RATIO_BITS + 1;
  localparam int Y_W        = 15;
  localparam int ROOT_W     = POS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FACE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID = CFG_IDX_W'(1);

  localparam logic [FACE_W-1:0] FACE_NEG_Z = FACE_W'(0);
  localparam logic [FACE_W-1:0] FACE_POS_Z = FACE_W'(1);
  localparam logic [FACE_W-1:0] FACE_POS_Y = FACE_W'(2);
  localparam logic [FACE_W-1:0] FACE_NEG_Y = FACE_W'(3);
  localparam logic [FACE_W-1:0] FACE_POS_X = FACE_W'(4);
  localparam logic [FACE_W-1:0] FACE_NEG_X = FACE_W'(5);

  localparam logic [GS_W-1:0] GRID_RESET = GS_W'(512);
  localparam logic [GS_W-1:0] GRID_MIN   = GS_W'(2);

  localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(16384);

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic [1:0] ax_n;
    logic [1:0] ax_a;
    logic [1:0] ax_b;
    logic       neg_n;
    logic       neg_a;
    logic       neg_b;
  } face_map_t;

  // Per-vertex data that rides alongside the arithmetic.
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              neg_u;
    logic              neg_v;
    logic              quad;
    logic [IDX_W-1:0]  vi;
    logic [IDX_W-1:0]  t0;
    logic [IDX_W-1:0]  p1;
    logic [IDX_W-1:0]  pg;
    logic [IDX_W-1:0]  pg1;
  } side_t;

  function automatic face_map_t face_lookup(input logic [FACE_W-1:0] f);
    face_map_t m;
    case (f)
      FACE_POS_Z: m = '{AX_Z, AX_Y, AX_X, 1'b0, 1'b0, 1'b1};
      FACE_POS_Y: m = '{AX_Y, AX_X, AX_Z, 1'b0, 1'b0, 1'b1};
      FACE_NEG_Y: m = '{AX_Y, AX_X, AX_Z, 1'b1, 1'b1, 1'b1};
      FACE_POS_X: m = '{AX_X, AX_Z, AX_Y, 1'b0, 1'b0, 1'b1};
      FACE_NEG_X: m = '{AX_X, AX_Z, AX_Y, 1'b1, 1'b1, 1'b1};
      default:    m = '{AX_Z, AX_Y, AX_X, 1'b1, 1'b1, 1'b1};
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/csv_if.sv
// Handshake channel interfaces: grid requests, vertex results, register writes.
`default_nettype none

interface csv_grid_if;
  logic                        valid;
  logic                        ready;
  logic [csv_pkg::COORD_W-1:0] col;
  logic [csv_pkg::COORD_W-1:0] row;
  modport source (output valid, col, row, input ready);
  modport sink (input valid, col, row, output ready);
endinterface

interface csv_vert_if;
  logic                             valid;
  logic                             ready;
  logic signed [csv_pkg::POS_W-1:0] pos_x;
  logic signed [csv_pkg::POS_W-1:0] pos_y;
  logic signed [csv_pkg::POS_W-1:0] pos_z;
  logic [csv_pkg::IDX_W-1:0]        vert_index;
  logic                             quad_valid;
  logic [csv_pkg::IDX_W-1:0]        tri_a0;
  logic [csv_pkg::IDX_W-1:0]        tri_a1;
  logic [csv_pkg::IDX_W-1:0]        tri_a2;
  logic [csv_pkg::IDX_W-1:0]        tri_b0;
  logic [csv_pkg::IDX_W-1:0]        tri_b1;
  logic [csv_pkg::IDX_W-1:0]        tri_b2;
  modport source (output valid, pos_x, pos_y, pos_z, vert_index, quad_valid,
                  tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vert_index, quad_valid,
                tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, output ready);
endinterface

interface csv_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [csv_pkg::CFG_IDX_W-1:0]  idx;
  logic [csv_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// File: rtl/cube_sphere_vertex_gen_top.sv
// Top level of the cube sphere vertex generator: registers, pipeline and result mapping.
// Pipeline: 6 setup, 29 divide and 16 root stages from an accepted request to its result.
// Throughput: one request per cycle when not stalled; every stage has its own valid bit.
// Backpressure collapses bubbles, so a stalled result only holds the full stages behind it.
// Reset clears all valid bits and sets face_select to -z and grid_size to 512.
`default_nettype none

`include "cube_sphere_vertex_gen_top_assert.svh"

module cube_sphere_vertex_gen_top #(
  parameter int MAX_GRID = 512
) (
  input  logic       clk,
  input  logic       rst,
  csv_cfg_if.sink    cfg,
  csv_grid_if.sink   grid,
  csv_vert_if.source vert
);
  import csv_pkg::*;

  // Configuration registers; user must write only while pipeline is empty (not enforced).
  logic [FACE_W-1:0] face_select;
  logic [GS_W-1:0]   grid_size;

  // Setup -> divider.
  logic                  su_valid;
  logic                  su_ready;
  logic [2:0][DEN_W-1:0] su_s;
  logic [DEN_W-1:0]      su_den;
  side_t                 su_side;

  // Divider -> root.
  logic                dv_valid;
  logic                dv_ready;
  logic [2:0][Q_W-1:0] dv_q;
  side_t               dv_side;

  // Root -> result mapping.
  logic                   sq_valid;
  logic [2:0][ROOT_W-1:0] sq_mag;
  side_t                  sq_side;

  face_map_t              fm;
  logic [2:0][POS_W-1:0]  pos;
  logic                   neg_a;
  logic                   neg_b;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_select <= FACE_NEG_Z;
      grid_size   <= GRID_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.idx)
        CFG_FACE: face_select <= cfg.data[FACE_W-1:0];
        CFG_GRID: grid_size   <= cfg.data[GS_W-1:0];
        default:  ;
      endcase
    end
  end

  // Clamp, square and form the three numerators and the shared denominator 6*d^4.
  csv_setup #(
    .MAX_GRID (MAX_GRID)
  ) u_setup (
    .clk         (clk),
    .rst         (rst),
    .face_select (face_select),
    .grid_size   (grid_size),
    .in_valid    (grid.valid),
    .in_ready    (grid.ready),
    .in_col      (grid.col),
    .in_row      (grid.row),
    .out_valid   (su_valid),
    .out_ready   (su_ready),
    .out_s       (su_s),
    .out_den     (su_den),
    .out_side    (su_side)
  );

  // Squared component as a Q28 fraction of one.
  csv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (su_valid),
    .in_ready  (su_ready),
    .in_s      (su_s),
    .in_den    (su_den),
    .in_side   (su_side),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // Component magnitude in Q2.14; the last root stage is the output register.
  csv_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_t      (dv_q),
    .in_side   (dv_side),
    .out_valid (sq_valid),
    .out_ready (vert.ready),
    .out_mag   (sq_mag),
    .out_side  (sq_side)
  );

  // Route normal, a and b lanes to x, y, z and apply the face signs.
  assign fm    = face_lookup(sq_side.face);
  assign neg_a = fm.neg_a ^ sq_side.neg_u;
  assign neg_b = fm.neg_b ^ sq_side.neg_v;

  always_comb begin
    pos          = '0;
    pos[fm.ax_n] = fm.neg_n ? -sq_mag[0] : sq_mag[0];
    pos[fm.ax_a] = neg_a ? -sq_mag[1] : sq_mag[1];
    pos[fm.ax_b] = neg_b ? -sq_mag[2] : sq_mag[2];
  end

  assign vert.valid      = sq_valid;
  assign vert.pos_x      = pos[AX_X];
  assign vert.pos_y      = pos[AX_Y];
  assign vert.pos_z      = pos[AX_Z];
  assign vert.vert_index = sq_side.vi;
  assign vert.quad_valid = sq_side.quad;
  assign vert.tri_a0     = sq_side.t0;
  assign vert.tri_a1     = sq_side.pg1;
  assign vert.tri_a2     = sq_side.pg;
  assign vert.tri_b0     = sq_side.t0;
  assign vert.tri_b1     = sq_side.p1;
  assign vert.tri_b2     = sq_side.pg1;

  `CSV_ASSERT_HOLDS(a_edge_tri_zero, vert.valid && !vert.quad_valid, vert.tri_a0 == '0 && vert.tri_a1 == '0 && vert.tri_b2 == '0, "corner indices nonzero on an edge vertex")
  `CSV_ASSERT_HOLDS(a_tri_step, vert.valid && vert.quad_valid, vert.tri_b1 == vert.tri_a0 + IDX_W'(1), "second corner is not index plus one")
  `CSV_ASSERT_HOLDS(a_pos_range, vert.valid, $signed(vert.pos_z) <= POS_ONE && $signed(vert.pos_z) >= -POS_ONE, "position outside the unit range")
  `CSV_ASSERT_HOLDS(a_drain_ready, vert.ready, grid.ready, "request refused while results drain")
  `CSV_ASSERT_NEXT(a_stall_full, !grid.ready, vert.valid, "request refused with no result waiting")

endmodule

`default_nettype wire

// File: rtl/csv_setup.sv
// Six-stage front end: clamp, squares, products and the numerators per axis.
`default_nettype none

module csv_setup #(
  parameter int MAX_GRID = 512
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [csv_pkg::FACE_W-1:0]              face_select,
  input  logic [csv_pkg::GS_W-1:0]                grid_size,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [csv_pkg::COORD_W-1:0]             in_col,
  input  logic [csv_pkg::COORD_W-1:0]             in_row,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [2:0][csv_pkg::DEN_W-1:0]          out_s,
  output logic [csv_pkg::DEN_W-1:0]               out_den,
  output csv_pkg::side_t                          out_side
);
  import csv_pkg::*;

  localparam int NST    = 6;
  localparam int GMAX_I = (MAX_GRID > (2 ** GS_W) - 1) ? (2 ** GS_W) - 1 : MAX_GRID;
  localparam logic [GS_W-1:0] GMAX = GS_W'(GMAX_I);

  logic [NST-1:0] v;
  logic [NST-1:0] ld;

  logic [GS_W-1:0]    g_cl;
  logic [GS_W-1:0]    gm1;
  logic [COORD_W-1:0] c_cl;
  logic [COORD_W-1:0] r_cl;

  logic [COORD_W-1:0] c1;
  logic [COORD_W-1:0] r1;
  logic [GS_W-1:0]    g1;
  logic [GS_W-1:0]    d1;
  logic [FACE_W-1:0]  face1;

  logic signed [U_W-1:0]       u2;
  logic signed [U_W-1:0]       v2;
  logic [SQ_W-1:0]             dd2;
  logic [IDX_W-1:0]            vi2;
  logic                        quad2;
  logic [GS_W-1:0]             g2;
  logic [FACE_W-1:0]           face2;
  logic [COORD_W+GS_W-1:0]     rg;
  logic [COORD_W+GS_W-1:0]     vi_full;

  logic signed [2*U_W-1:0] usq;
  logic signed [2*U_W-1:0] vsq;
  logic [SQ_W-1:0]         uu3;
  logic [SQ_W-1:0]         vv3;
  logic [SQ_W-1:0]         dd3;
  side_t                   side3;
  side_t                   side_next;

  logic [DD2_W-1:0] ddsq4;
  logic [DD2_W-1:0] uv4;
  logic [DD3_W-1:0] t3_4;
  logic [SUV_W-1:0] suv4;
  logic [DD3_W-1:0] am4;
  logic [DD3_W-1:0] bm4;
  logic [SQ_W-1:0]  uu4;
  logic [SQ_W-1:0]  vv4;
  logic [DD3_W-1:0] t3;
  side_t            side4;

  logic [DEN_W-1:0] den5;
  logic [DEN_W-1:0] p5;
  logic [DEN_W-1:0] sa5;
  logic [DEN_W-1:0] sb5;
  logic [DEN_W-1:0] uv2_5;
  side_t            side5;

  logic [DEN_W-1:0] sn6;
  logic [DEN_W-1:0] sa6;
  logic [DEN_W-1:0] sb6;
  logic [DEN_W-1:0] den6;
  side_t            side6;

  always_comb begin
    ld[NST-1] = !v[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  // Clamp grid size and coordinates.
  always_comb begin
    if (grid_size < GRID_MIN) begin
      g_cl = GRID_MIN;
    end else if (grid_size > GMAX) begin
      g_cl = GMAX;
    end else begin
      g_cl = grid_size;
    end
    gm1  = g_cl - GS_W'(1);
    c_cl = ({1'b0, in_col} > gm1) ? gm1[COORD_W-1:0] : in_col;
    r_cl = ({1'b0, in_row} > gm1) ? gm1[COORD_W-1:0] : in_row;
  end

  assign rg      = r1 * g1;
  assign vi_full = rg + (COORD_W + GS_W)'(c1);
  assign usq     = u2 * u2;
  assign vsq     = v2 * v2;
  assign t3      = (DD3_W'(dd3) << 1) + DD3_W'(dd3);

  always_comb begin
    side_next       = '0;
    side_next.face  = face2;
    side_next.neg_u = u2[U_W-1];
    side_next.neg_v = v2[U_W-1];
    side_next.quad  = quad2;
    side_next.vi    = vi2;
    if (quad2) begin
      side_next.t0  = vi2;
      side_next.p1  = vi2 + IDX_W'(1);
      side_next.pg  = vi2 + IDX_W'(g2);
      side_next.pg1 = vi2 + IDX_W'(g2) + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0] && in_valid) begin
      c1    <= c_cl;
      r1    <= r_cl;
      g1    <= g_cl;
      d1    <= gm1;
      face1 <= face_select;
    end
    if (ld[1] && v[0]) begin
      u2    <= $signed({1'b0, c1, 1'b0}) - $signed({1'b0, d1});
      v2    <= $signed({1'b0, r1, 1'b0}) - $signed({1'b0, d1});
      dd2   <= d1 * d1;
      vi2   <= vi_full[IDX_W-1:0];
      quad2 <= ({1'b0, c1} < d1) && ({1'b0, r1} < d1);
      g2    <= g1;
      face2 <= face1;
    end
    if (ld[2] && v[1]) begin
      uu3   <= usq[SQ_W-1:0];
      vv3   <= vsq[SQ_W-1:0];
      dd3   <= dd2;
      side3 <= side_next;
    end
    if (ld[3] && v[2]) begin
      ddsq4 <= dd3 * dd3;
      uv4   <= uu3 * vv3;
      t3_4  <= t3;
      suv4  <= SUV_W'(uu3) + SUV_W'(vv3);
      am4   <= t3 - DD3_W'(vv3);
      bm4   <= t3 - DD3_W'(uu3);
      uu4   <= uu3;
      vv4   <= vv3;
      side4 <= side3;
    end
    if (ld[4] && v[3]) begin
      den5  <= (DEN_W'(ddsq4) << 2) + (DEN_W'(ddsq4) << 1);
      p5    <= t3_4 * suv4;
      sa5   <= uu4 * am4;
      sb5   <= vv4 * bm4;
      uv2_5 <= DEN_W'(uv4) << 1;
      side5 <= side4;
    end
    if (ld[5] && v[4]) begin
      sn6   <= den5 + uv2_5 - p5;
      sa6   <= sa5;
      sb6   <= sb5;
      den6  <= den5;
      side6 <= side5;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v[NST-1];
  assign out_s     = {sb6, sa6, sn6};
  assign out_den   = den6;
  assign out_side  = side6;

endmodule

`default_nettype wire

// File: rtl/csv_div.sv
// Pipelined restoring divider: floor(s * 2^28 / den) for three lanes, one bit a stage.
`default_nettype none

module csv_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0][csv_pkg::DEN_W-1:0]      in_s,
  input  logic [csv_pkg::DEN_W-1:0]           in_den,
  input  csv_pkg::side_t                      in_side,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0][csv_pkg::Q_W-1:0]        out_q,
  output csv_pkg::side_t                      out_side
);
  import csv_pkg::*;

  localparam int NST = RATIO_BITS + 1;

  logic [NST-1:0] v;
  logic [NST-1:0] ld;

  logic [2:0][DEN_W-1:0] rm      [NST];
  logic [2:0][Q_W-1:0]   qq      [NST];
  logic [DEN_W-1:0]      dn      [NST];
  side_t                 sd      [NST];
  logic [2:0][DEN_W-1:0] rm_next [NST];
  logic [2:0][Q_W-1:0]   qq_next [NST];

  always_comb begin
    ld[NST-1] = !v[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  // First stage takes the integer part (0 or 1, as s never exceeds den).
  always_comb begin
    logic [DEN_W:0] sh;
    logic           ge;
    for (int l = 0; l < 3; l++) begin
      ge            = in_s[l] >= in_den;
      rm_next[0][l] = ge ? in_s[l] - in_den : in_s[l];
      qq_next[0][l] = {{(Q_W-1){1'b0}}, ge};
    end
    for (int k = 1; k < NST; k++) begin
      for (int l = 0; l < 3; l++) begin
        sh            = {rm[k-1][l], 1'b0};
        ge            = sh >= {1'b0, dn[k-1]};
        rm_next[k][l] = ge ? DEN_W'(sh - {1'b0, dn[k-1]}) : sh[DEN_W-1:0];
        qq_next[k][l] = {qq[k-1][l][Q_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0] && in_valid) begin
      rm[0] <= rm_next[0];
      qq[0] <= qq_next[0];
      dn[0] <= in_den;
      sd[0] <= in_side;
    end
    for (int k = 1; k < NST; k++) begin
      if (ld[k] && v[k-1]) begin
        rm[k] <= rm_next[k];
        qq[k] <= qq_next[k];
        dn[k] <= dn[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v[NST-1];
  assign out_q     = qq[NST-1];
  assign out_side  = sd[NST-1];

endmodule

`default_nettype wire

// File: rtl/csv_sqrt.sv
// Pipelined square root, one result bit a stage, then round to nearest.
`default_nettype none

module csv_sqrt (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0][csv_pkg::Q_W-1:0]        in_t,
  input  csv_pkg::side_t                      in_side,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0][csv_pkg::ROOT_W-1:0]     out_mag,
  output csv_pkg::side_t                      out_side
);
  import csv_pkg::*;

  localparam int NST  = Y_W + 1;
  localparam int T_W  = Q_W;
  localparam int TR_W = T_W + 2;

  typedef struct packed {
    logic [Y_W-1:0] y;
    logic [T_W-1:0] rem;
  } rstep_t;

  logic [NST-1:0] v;
  logic [NST-1:0] ld;

  rstep_t [2:0]           st      [Y_W];
  rstep_t [2:0]           st_next [Y_W];
  side_t                  sd      [NST];
  logic [2:0][ROOT_W-1:0] mag;

  // rem holds t - y*y; set bit b when (y + 2^b)^2 still fits.
  function automatic rstep_t sq_step(input logic [Y_W-1:0] y, input logic [T_W-1:0] rem,
                                     input int b);
    logic [TR_W-1:0] trial;
    rstep_t          res;
    trial   = (TR_W'(y) << (b + 1)) + (TR_W'(1) << (2 * b));
    res.y   = y;
    res.rem = rem;
    if (TR_W'(rem) >= trial) begin
      res.rem = T_W'(TR_W'(rem) - trial);
      res.y   = y | (Y_W'(1) << b);
    end
    return res;
  endfunction

  always_comb begin
    ld[NST-1] = !v[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      st_next[0][l] = sq_step('0, in_t[l], Y_W - 1);
    end
    for (int j = 1; j < Y_W; j++) begin
      for (int l = 0; l < 3; l++) begin
        st_next[j][l] = sq_step(st[j-1][l].y, st[j-1][l].rem, Y_W - 1 - j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0] && in_valid) begin
      st[0] <= st_next[0];
      sd[0] <= in_side;
    end
    for (int j = 1; j < Y_W; j++) begin
      if (ld[j] && v[j-1]) begin
        st[j] <= st_next[j];
        sd[j] <= sd[j-1];
      end
    end
    if (ld[NST-1] && v[NST-2]) begin
      for (int l = 0; l < 3; l++) begin
        mag[l] <= ROOT_W'(st[Y_W-1][l].y) +
                  ROOT_W'(st[Y_W-1][l].rem > T_W'(st[Y_W-1][l].y));
      end
      sd[NST-1] <= sd[NST-2];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v[NST-1];
  assign out_mag   = mag;
  assign out_side  = sd[NST-1];

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the cube sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import csv_pkg::*;

  // One expected vertex result.
  typedef struct {
    logic [POS_W-1:0] px, py, pz;
    logic [IDX_W-1:0] vi;
    logic             quad;
    logic [IDX_W-1:0] a0, a1, a2, b0, b1, b2;
  } vertex_t;

  // Directed stimulus row: register settings, grid point, optional typed expectation.
  typedef struct {
    logic [FACE_W-1:0]   face;
    logic [CFG_DATA_W-1:0] grid;
    int                  col, row;
    bit                  typed;
    int                  px, py, pz;
  } dir_row_t;

  localparam int LATENCY = 51;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csv_cfg_if  cfg ();
  csv_grid_if grid ();
  csv_vert_if vert ();

  cube_sphere_vertex_gen_top dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .grid (grid),
    .vert (vert)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of the registers.
  logic [FACE_W-1:0] face_reg = FACE_NEG_Z;
  logic [GS_W-1:0]   grid_reg = GRID_RESET;

  vertex_t expected_verts[$];
  int      errors = 0;
  bit      calm = 1'b0;   // no idling in the last part of the run

  // floor(s * 2^28 / den), done as restoring division.
  function automatic longint unsigned ratio28(longint unsigned s, longint unsigned den);
    longint unsigned q, r;
    q = s / den;
    r = s % den;
    for (int i = 0; i < RATIO_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Root rounded to nearest, then signed into Q2.14.
  function automatic logic [POS_W-1:0] q214(longint unsigned s, longint unsigned den,
                                            bit neg);
    longint unsigned t, y, c;
    t = ratio28(s, den);
    y = 0;
    for (int b = 14; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (c * c <= t) y = c;
    end
    if (t - y * y > y) y++;
    return neg ? POS_W'(17'h10000 - y) : POS_W'(y);
  endfunction

  function automatic vertex_t sphere_vertex(logic [COORD_W-1:0] col_in,
                                            logic [COORD_W-1:0] row_in);
    face_map_t fm;
    longint unsigned g, c, r, d, uu, vv, dd, den;
    longint u, v, ivi;
    logic [POS_W-1:0] pos[3];
    vertex_t e;
    fm = face_lookup(face_reg);
    g = grid_reg;
    if (g < 2) g = 2;
    if (g > 512) g = 512;
    c = col_in;
    r = row_in;
    if (c > g - 1) c = g - 1;
    if (r > g - 1) r = g - 1;
    d = g - 1;
    u = 2 * c - d;
    v = 2 * r - d;
    uu = u * u;
    vv = v * v;
    dd = d * d;
    den = 6 * dd * dd;
    pos[fm.ax_n] = q214(den + 2 * uu * vv - 3 * dd * (uu + vv), den, fm.neg_n);
    pos[fm.ax_a] = q214(uu * (3 * dd - vv), den, fm.neg_a != (u < 0));
    pos[fm.ax_b] = q214(vv * (3 * dd - uu), den, fm.neg_b != (v < 0));
    ivi = c + r * g;
    e.px = pos[0];
    e.py = pos[1];
    e.pz = pos[2];
    e.vi = IDX_W'(ivi);
    e.quad = (c < g - 1) && (r < g - 1);
    e.a0 = e.quad ? IDX_W'(ivi) : '0;
    e.a1 = e.quad ? IDX_W'(ivi + g + 1) : '0;
    e.a2 = e.quad ? IDX_W'(ivi + g) : '0;
    e.b0 = e.quad ? IDX_W'(ivi) : '0;
    e.b1 = e.quad ? IDX_W'(ivi + 1) : '0;
    e.b2 = e.quad ? IDX_W'(ivi + g + 1) : '0;
    return e;
  endfunction

  // Report one field mismatch.
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result side: random stall bursts, compare each accepted result with the oldest one.
  initial begin
    vert.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        vert.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      vert.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && vert.valid && vert.ready) begin
      if (expected_verts.size() == 0) begin
        $error("vertex result with no request outstanding");
        errors++;
      end else begin
        vertex_t e;
        e = expected_verts.pop_front();
        check_field("pos_x", $signed(e.px), vert.pos_x);
        check_field("pos_y", $signed(e.py), vert.pos_y);
        check_field("pos_z", $signed(e.pz), vert.pos_z);
        check_field("vert_index", e.vi, vert.vert_index);
        check_field("quad_valid", e.quad, vert.quad_valid);
        check_field("tri_a0", e.a0, vert.tri_a0);
        check_field("tri_a1", e.a1, vert.tri_a1);
        check_field("tri_a2", e.a2, vert.tri_a2);
        check_field("tri_b0", e.b0, vert.tri_b0);
        check_field("tri_b1", e.b1, vert.tri_b1);
        check_field("tri_b2", e.b2, vert.tri_b2);
      end
    end
  end

  // Write one register and mirror it in the predictor; the caller drops valid.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.idx   <= idx;
    cfg.data  <= data;
    @(posedge clk iff cfg.ready);
    if (idx == CFG_FACE) face_reg = FACE_W'(data);
    else if (idx == CFG_GRID) grid_reg = GS_W'(data);
  endtask

  // Drop requests, drain outstanding results, then let the pipe settle.
  task automatic drain;
    grid.valid <= 1'b0;
    wait (expected_verts.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Send one grid request; queue its expectation (a typed one overrides positions).
  task automatic send_point(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
                            bit typed = 0, int px = 0, int py = 0, int pz = 0);
    vertex_t e;
    if (!calm && $urandom_range(0, 4) == 0) begin
      grid.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    e = sphere_vertex(c, r);
    if (typed) begin
      e.px = POS_W'(px);
      e.py = POS_W'(py);
      e.pz = POS_W'(pz);
    end
    grid.valid <= 1'b1;
    grid.col   <= c;
    grid.row   <= r;
    expected_verts.push_back(e);
    @(posedge clk iff grid.ready);
  endtask

  // Directed rows. Corners of a 2x2 face land at (+-1,+-1,+-1)/sqrt3 = 9459;
  // the center of an odd grid lands exactly on the face normal.
  dir_row_t dir_rows[] = '{
    '{FACE_NEG_Z, 10'd3,   1,   1,   1, 0, 0, -16384},
    '{FACE_POS_Z, 10'd3,   1,   1,   1, 0, 0, 16384},
    '{FACE_POS_Y, 10'd3,   1,   1,   1, 0, 16384, 0},
    '{FACE_NEG_Y, 10'd3,   1,   1,   1, 0, -16384, 0},
    '{FACE_POS_X, 10'd3,   1,   1,   1, 16384, 0, 0},
    '{FACE_NEG_X, 10'd3,   1,   1,   1, -16384, 0, 0},
    '{3'd6,       10'd3,   1,   1,   1, 0, 0, -16384},  // unknown face acts as -z
    '{3'd7,       10'd3,   1,   1,   1, 0, 0, -16384},
    '{FACE_POS_Z, 10'd2,   0,   0,   0, 0, 0, 0},
    '{FACE_POS_Z, 10'd2,   1,   1,   0, 0, 0, 0},       // last row and column
    '{FACE_POS_X, 10'd0,   0,   1,   0, 0, 0, 0},       // grid below 2 acts as 2
    '{FACE_POS_X, 10'd1,   1,   0,   0, 0, 0, 0},
    '{FACE_NEG_Z, 10'd512, 0,   0,   0, 0, 0, 0},
    '{FACE_NEG_Z, 10'd512, 511, 511, 0, 0, 0, 0},
    '{FACE_NEG_Z, 10'd512, 510, 510, 0, 0, 0, 0},
    '{FACE_NEG_Y, 10'd1023, 511, 0,  0, 0, 0, 0},       // grid above max
    '{FACE_NEG_Y, 10'd600, 0,   511, 0, 0, 0, 0},
    '{FACE_POS_Y, 10'd5,   511, 3,   0, 0, 0, 0},       // coordinates saturate
    '{FACE_POS_Y, 10'd5,   2,   511, 0, 0, 0, 0},
    '{FACE_NEG_X, 10'd17,  256, 170, 0, 0, 0, 0},
    '{FACE_NEG_X, 10'd300, 299, 0,   0, 0, 0, 0}
  };

  initial begin
    int n_random;
    logic [GS_W-1:0] g;
    cfg.valid  <= 1'b0;
    cfg.idx    <= CFG_FACE;
    cfg.data   <= '0;
    grid.valid <= 1'b0;
    grid.col   <= '0;
    grid.row   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values: grid 512, face -z, so the first corner is (+c, +c, -c).
    send_point(9'd0, 9'd0);
    drain();

    foreach (dir_rows[i]) begin
      if (dir_rows[i].face != face_reg || dir_rows[i].grid != grid_reg) begin
        drain();
        write_reg(CFG_FACE, CFG_DATA_W'(dir_rows[i].face));
        write_reg(CFG_GRID, dir_rows[i].grid);
        cfg.valid <= 1'b0;
      end
      send_point(dir_rows[i].col, dir_rows[i].row, dir_rows[i].typed,
                 dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
    end

    // Random phases: each picks a face and grid, then walks random points.
    n_random = 0;
    while (n_random < 450) begin
      drain();
      case ($urandom_range(0, 5))
        0: g = GS_W'($urandom_range(0, 1));
        1: g = GS_W'(512);
        2: g = GS_W'($urandom_range(513, 1023));
        3: g = GS_W'($urandom_range(2, 9));
        default: g = GS_W'($urandom_range(2, 512));
      endcase
      write_reg(CFG_FACE, CFG_DATA_W'($urandom_range(0, 7)));
      write_reg(CFG_GRID, g);
      cfg.valid <= 1'b0;
      if (n_random > 380) calm = 1'b1;
      repeat ($urandom_range(10, 40)) begin
        logic [COORD_W-1:0] c, r;
        if ($urandom_range(0, 9) == 0) begin
          c = COORD_W'($urandom);
          r = COORD_W'($urandom);
        end else begin
          c = COORD_W'($urandom_range(0, (g < 2 ? 2 : g > 512 ? 512 : g) - 1));
          r = COORD_W'($urandom_range(0, (g < 2 ? 2 : g > 512 ? 512 : g) - 1));
        end
        send_point(c, r);
        n_random++;
      end
    end

    grid.valid <= 1'b0;
    wait (expected_verts.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// File: cube_sphere_vertex_gen_top.f
+incdir+rtl
rtl/csv_pkg.sv
rtl/csv_if.sv
rtl/csv_setup.sv
rtl/csv_div.sv
rtl/csv_sqrt.sv
rtl/cube_sphere_vertex_gen_top.sv
tb/sv/tb_top.sv
